@@ rtl/core/qfud_pkg.sv @@
// Shared types, character codes and helper functions of the query-field decoder.
`default_nettype none

package qfud_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpD   = 8'h44;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindFound   = 2'd1;
  localparam logic [1:0] KindMissing = 2'd2;

  localparam logic CfgKeyText   = 1'b0;
  localparam logic CfgKeyLength = 1'b1;

  typedef enum logic [2:0] {
    ScanSeek,
    ScanValue,
    ScanEsc1,
    ScanEsc2,
    ScanDone
  } scan_mode_e;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqRead,
    SeqPop,
    SeqByte,
    SeqStatus
  } seq_state_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       found;
    logic       drop_queue;
  } scan_res_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/qfud_scan.sv @@
// Key match and percent-decode scanner of the query-field decoder.
`default_nettype none

module qfud_scan #(
  parameter int KEY_BYTES = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 advance_i,
  input  wire logic [7:0]           char_byte_i,
  input  wire logic                 end_of_text_i,
  input  wire logic [63:0]          key_text_i,
  input  wire logic [3:0]           key_length_i,
  output qfud_pkg::scan_res_t       res_o
);

  qfud_pkg::scan_mode_e mode_q, mode_d;
  logic [KEY_BYTES:0]   match_q, match_d, match_next;
  logic [7:0]           esc_q, esc_d;
  logic [3:0]           key_len;
  logic                 key_hit;

  always_comb begin
    key_len = key_length_i;
    if (key_len == 4'd0) key_len = 4'd1;
    if (key_len > 4'(KEY_BYTES)) key_len = 4'(KEY_BYTES);
  end

  always_comb begin
    match_next = '0;
    key_hit    = 1'b0;
    for (int p = 0; p < KEY_BYTES; p++) begin
      if ((4'(p) < key_len) && match_q[p] && (key_text_i[8*p +: 8] == char_byte_i)) begin
        match_next[p+1] = 1'b1;
      end
    end
    if (char_byte_i == qfud_pkg::CharAmp) match_next[0] = 1'b1;
    for (int p = 1; p <= KEY_BYTES; p++) begin
      if (key_len == 4'(p)) key_hit = match_next[p];
    end
  end

  always_comb begin
    mode_d  = mode_q;
    match_d = match_q;
    esc_d   = esc_q;
    unique case (mode_q)
      qfud_pkg::ScanSeek: begin
        match_d = match_next;
        if (key_hit) mode_d = qfud_pkg::ScanValue;
      end
      qfud_pkg::ScanValue: begin
        if (char_byte_i == qfud_pkg::CharAmp) mode_d = qfud_pkg::ScanDone;
        else if (char_byte_i == qfud_pkg::CharPct) mode_d = qfud_pkg::ScanEsc1;
      end
      qfud_pkg::ScanEsc1: begin
        esc_d  = char_byte_i;
        mode_d = qfud_pkg::ScanEsc2;
      end
      qfud_pkg::ScanEsc2: mode_d = qfud_pkg::ScanValue;
      default:            mode_d = qfud_pkg::ScanDone;
    endcase
    if (end_of_text_i) begin
      mode_d  = qfud_pkg::ScanSeek;
      match_d = (KEY_BYTES+1)'(1);
      esc_d   = 8'd0;
    end
  end

  always_comb begin
    res_o = '{has_byte: 1'b0, data: 8'd0, found: 1'b1, drop_queue: 1'b0};
    unique case (mode_q)
      qfud_pkg::ScanSeek: res_o.found = key_hit;
      qfud_pkg::ScanValue: begin
        if (char_byte_i == qfud_pkg::CharAmp) begin
          res_o.drop_queue = 1'b1;
        end else if (char_byte_i == qfud_pkg::CharPlus) begin
          res_o.has_byte = 1'b1;
          res_o.data     = qfud_pkg::CharSpace;
        end else if (char_byte_i != qfud_pkg::CharPct) begin
          res_o.has_byte = 1'b1;
          res_o.data     = char_byte_i;
        end
      end
      qfud_pkg::ScanEsc2: begin
        if (esc_q == qfud_pkg::CharZero && char_byte_i == qfud_pkg::CharUpA) begin
          res_o.has_byte = 1'b1;
          res_o.data     = qfud_pkg::CharLf;
        end else if (!(esc_q == qfud_pkg::CharZero && char_byte_i == qfud_pkg::CharUpD)) begin
          res_o.has_byte = 1'b1;
          res_o.data     = {qfud_pkg::hex_value(esc_q), qfud_pkg::hex_value(char_byte_i)};
        end
      end
      default: res_o.found = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= qfud_pkg::ScanSeek;
      match_q <= (KEY_BYTES+1)'(1);
      esc_q   <= 8'd0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      match_q <= match_d;
      esc_q   <= esc_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/query_field_url_decoder.sv @@
// Top level of the query-field URL decoder: whitespace queue memory and result sequencer.
// Takes a form-encoded query string one byte per request, finds the first field whose
// start matches the configured key (including '='), and returns its URL-decoded value
// byte by byte with trailing whitespace trimmed, then one status result with last set.
// A byte that yields a decoded byte holds off further requests until it is loaded into
// the output register. Held whitespace lives in a single-port-read queue memory with a
// registered read, so each held byte drained ahead of a non-space byte (or evicted when
// the queue fills) passes through a read state and then a pop state. A new request is
// taken while the last result still waits in the output register. Configure the key
// only between strings.
`default_nettype none

module query_field_url_decoder #(
  parameter int PENDING_DEPTH = 16,
  parameter int KEY_BYTES     = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        end_of_text_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  kind_o,
  output      logic [7:0]  value_byte_o,
  output      logic        last_o
);

  localparam int PtrW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CntW = $clog2(PENDING_DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(PENDING_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(PENDING_DEPTH);

  logic [63:0] key_text_q;
  logic [3:0]  key_length_q;

  logic                  in_accept;
  qfud_pkg::scan_res_t   sres;
  qfud_pkg::seq_state_e  state_q, state_d;

  logic [7:0]      pend_mem [PENDING_DEPTH];
  logic [7:0]      rdata_q;
  logic [PtrW-1:0] head_q, head_d, tail;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic            mem_we, mem_re;

  logic       flush_all_q, flush_all_d;
  logic       end_q, end_d;
  logic       found_q, found_d;
  logic [7:0] byte_q, byte_d;
  logic       push_white, full_after;

  logic       out_free, out_load;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] value_q;
  logic       last_q;

  assign in_stall_o = (state_q != qfud_pkg::SeqIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q   <= 64'd0;
      key_length_q <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qfud_pkg::CfgKeyText:   key_text_q   <= cfg_data_i;
        qfud_pkg::CfgKeyLength: key_length_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  qfud_scan #(
    .KEY_BYTES(KEY_BYTES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_accept),
    .char_byte_i  (char_byte_i),
    .end_of_text_i(end_of_text_i),
    .key_text_i   (key_text_q),
    .key_length_i (key_length_q),
    .res_o        (sres)
  );

  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(PENDING_DEPTH)) tail_sum = tail_sum - SumW'(PENDING_DEPTH);
    tail = tail_sum[PtrW-1:0];
  end

  assign push_white = sres.has_byte && qfud_pkg::is_white(sres.data);
  assign full_after = (count_q + CntW'(1)) == CntFull;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qfud_pkg::SeqIdle: begin
        if (in_accept) begin
          if (push_white && full_after) state_d = qfud_pkg::SeqRead;
          else if (sres.has_byte && !push_white && count_q != '0) state_d = qfud_pkg::SeqRead;
          else if (sres.has_byte && !push_white) state_d = qfud_pkg::SeqByte;
          else if (end_of_text_i) state_d = qfud_pkg::SeqStatus;
        end
      end
      qfud_pkg::SeqRead: state_d = qfud_pkg::SeqPop;
      qfud_pkg::SeqPop: begin
        if (out_free) begin
          if (flush_all_q && count_q > CntW'(1)) state_d = qfud_pkg::SeqRead;
          else if (flush_all_q) state_d = qfud_pkg::SeqByte;
          else if (end_q) state_d = qfud_pkg::SeqStatus;
          else state_d = qfud_pkg::SeqIdle;
        end
      end
      qfud_pkg::SeqByte: begin
        if (out_free) state_d = end_q ? qfud_pkg::SeqStatus : qfud_pkg::SeqIdle;
      end
      qfud_pkg::SeqStatus: begin
        if (out_free) state_d = qfud_pkg::SeqIdle;
      end
      default: state_d = qfud_pkg::SeqIdle;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    flush_all_d = flush_all_q;
    end_d       = end_q;
    found_d     = found_q;
    byte_d      = byte_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    out_kind    = qfud_pkg::KindByte;
    out_byte    = 8'd0;
    out_last    = 1'b0;
    unique case (state_q)
      qfud_pkg::SeqIdle: begin
        if (in_accept) begin
          end_d       = end_of_text_i;
          found_d     = sres.found;
          byte_d      = sres.data;
          flush_all_d = sres.has_byte && !push_white;
          if (sres.drop_queue) begin
            head_d  = '0;
            count_d = '0;
          end else if (push_white) begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
      end
      qfud_pkg::SeqRead: mem_re = 1'b1;
      qfud_pkg::SeqPop: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = rdata_q;
          head_d   = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
          count_d  = count_q - CntW'(1);
        end
      end
      qfud_pkg::SeqByte: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = byte_q;
        end
      end
      qfud_pkg::SeqStatus: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = found_q ? qfud_pkg::KindFound : qfud_pkg::KindMissing;
          out_last = 1'b1;
          head_d   = '0;
          count_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) pend_mem[tail] <= sres.data;
    if (mem_re) rdata_q <= pend_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qfud_pkg::SeqIdle;
      head_q      <= '0;
      count_q     <= '0;
      flush_all_q <= 1'b0;
      end_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      flush_all_q <= flush_all_d;
      end_q       <= end_d;
      found_q     <= found_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_load) begin
      kind_q  <= out_kind;
      value_q <= out_byte;
      last_q  <= out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_byte_o = value_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

@@ rtl/core/qfud_checker.sv @@
// Port-level checker of the query-field decoder and its bind to the top level.
`default_nettype none

module qfud_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] value_byte_o,
  input wire logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(value_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  a_byte_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == qfud_pkg::KindByte |-> !last_o)
    else $error("value byte marked last");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != qfud_pkg::KindByte |->
      last_o && value_byte_o == 8'd0 &&
      (kind_o == qfud_pkg::KindFound || kind_o == qfud_pkg::KindMissing))
    else $error("malformed status result");

endmodule

bind query_field_url_decoder qfud_checker u_qfud_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .value_byte_o(value_byte_o),
  .last_o      (last_o)
);

`default_nettype wire
